### rtl/vpu_pkg.sv
`timescale 1ns / 1ps
package vpu_pkg;

    localparam int POS_W          = 22;
    localparam int IDX_W          = 10;
    localparam int DT_W           = 32;
    localparam int OP_W           = 2;
    localparam int S_TDATA_W      = 184;
    localparam int M_TDATA_W      = 56;
    localparam int CFG_AW         = 5;
    localparam int CFG_DW         = 32;
    localparam int NUM_POINTS_DEF = 1024;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int DAMP_SHIFT     = 16;
    localparam int DT_SHIFT       = 32;

    typedef enum logic [OP_W-1:0] {
        OP_INIT   = 2'd0,
        OP_PIN    = 2'd1,
        OP_SET    = 2'd2,
        OP_UPDATE = 2'd3
    } op_t;

    localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd0;
    localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DAMPING       = 3'd2;
    localparam logic [2:0] REG_ELASTICITY    = 3'd3;
    localparam logic [2:0] REG_ACCEL_X       = 3'd4;
    localparam logic [2:0] REG_ACCEL_Y       = 3'd5;
    localparam logic [2:0] REG_CURSOR_SIZE   = 3'd6;
    localparam logic [2:0] REG_BLAST         = 3'd7;

    typedef struct packed {
        logic        [19:0] window_width;
        logic        [19:0] window_height;
        logic        [16:0] damping_factor;
        logic        [15:0] elasticity;
        logic signed [23:0] accel_x;
        logic signed [23:0] accel_y;
        logic        [15:0] cursor_size;
        logic signed [15:0] blast_intensity;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_IMPULSE,
        ST_INTEG,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd;
        logic imp;
        logic vel;
        logic wb;
        logic clr;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } status_t;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [39:0] v);
        logic signed [39:0] hi;
        logic signed [39:0] lo;
        hi = 40'sd2097151;
        lo = -40'sd2097152;
        if (v > hi) begin
            return hi[POS_W-1:0];
        end else if (v < lo) begin
            return lo[POS_W-1:0];
        end
        return v[POS_W-1:0];
    endfunction

endpackage

### rtl/vpu_cfg.sv
`timescale 1ns / 1ps
module vpu_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vpu_pkg::CFG_AW-1:0]  paddr,
    input  logic [vpu_pkg::CFG_DW-1:0]  pwdata,
    output logic [vpu_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    output vpu_pkg::cfg_t               cfg
);
    import vpu_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] sel_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign sel_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_width    <= 20'd204800;
            cfg_reg.window_height   <= 20'd153600;
            cfg_reg.damping_factor  <= 17'd65536;
            cfg_reg.elasticity      <= 16'd2560;
            cfg_reg.accel_x         <= 24'sd0;
            cfg_reg.accel_y         <= 24'sd256000;
            cfg_reg.cursor_size     <= 16'd2560;
            cfg_reg.blast_intensity <= 16'sd0;
        end else if (wr_en) begin
            unique case (sel_idx)
                REG_WINDOW_WIDTH:  cfg_reg.window_width    <= pwdata[19:0];
                REG_WINDOW_HEIGHT: cfg_reg.window_height   <= pwdata[19:0];
                REG_DAMPING:       cfg_reg.damping_factor  <= pwdata[16:0];
                REG_ELASTICITY:    cfg_reg.elasticity      <= pwdata[15:0];
                REG_ACCEL_X:       cfg_reg.accel_x         <= pwdata[23:0];
                REG_ACCEL_Y:       cfg_reg.accel_y         <= pwdata[23:0];
                REG_CURSOR_SIZE:   cfg_reg.cursor_size     <= pwdata[15:0];
                REG_BLAST:         cfg_reg.blast_intensity <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sel_idx)
            REG_WINDOW_WIDTH:  prdata = 32'(cfg_reg.window_width);
            REG_WINDOW_HEIGHT: prdata = 32'(cfg_reg.window_height);
            REG_DAMPING:       prdata = 32'(cfg_reg.damping_factor);
            REG_ELASTICITY:    prdata = 32'(cfg_reg.elasticity);
            REG_ACCEL_X:       prdata = {8'd0, cfg_reg.accel_x};
            REG_ACCEL_Y:       prdata = {8'd0, cfg_reg.accel_y};
            REG_CURSOR_SIZE:   prdata = 32'(cfg_reg.cursor_size);
            REG_BLAST:         prdata = {16'd0, cfg_reg.blast_intensity};
            default:           prdata = '0;
        endcase
    end

endmodule

### rtl/vpu_ctrl.sv
`timescale 1ns / 1ps
module vpu_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  vpu_pkg::status_t st,
    output vpu_pkg::cmd_t    cmd
);
    import vpu_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (st.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_IMPULSE;
            end
            ST_IMPULSE: begin
                cmd.imp    = 1'b1;
                state_next = ST_INTEG;
            end
            ST_INTEG: begin
                cmd.vel    = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                // hold until the output register is free
                if (st.out_free) begin
                    cmd.wb     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### rtl/vpu_dp.sv
`timescale 1ns / 1ps
module vpu_dp #(
    parameter int NUM_POINTS = vpu_pkg::NUM_POINTS_DEF,
    parameter int FRAC_BITS  = vpu_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  vpu_pkg::cmd_t                  cmd,
    output vpu_pkg::status_t               st,
    input  vpu_pkg::cfg_t                  cfg,
    input  logic [vpu_pkg::OP_W-1:0]       s_tuser,
    input  logic [vpu_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [vpu_pkg::M_TDATA_W-1:0]  m_tdata
);
    import vpu_pkg::*;

    localparam int AW  = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
    localparam int OFF = 2 << FRAC_BITS;
    localparam int RW  = 2 * POS_W;

    logic [RW-1:0] cur_mem   [NUM_POINTS];
    logic [RW-1:0] prev_mem  [NUM_POINTS];
    logic [RW-1:0] start_mem [NUM_POINTS];
    logic          pin_mem   [NUM_POINTS];

    // latched input word
    op_t                     op_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic                    in_range_reg;
    logic signed [POS_W-1:0] px_reg, py_reg, mx_reg, my_reg, mpx_reg, mpy_reg;
    logic [DT_W-1:0]         dt2_reg;
    logic                    left_reg, right_reg, blast_reg;

    logic [RW-1:0] cur_rd_reg, prev_rd_reg, start_rd_reg;
    logic          pin_rd_reg;

    logic signed [POS_W-1:0] pex_reg, pey_reg;
    logic                    sel_reg;
    logic signed [25:0]      tx_reg, ty_reg;
    logic signed [24:0]      vx_reg, vy_reg;
    logic signed [26:0]      ax_reg, ay_reg;

    logic [AW-1:0]  clr_cnt_reg;
    logic           m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [AW-1:0] addr;
    assign addr = AW'(idx_reg);

    assign st.clr_last = (clr_cnt_reg == AW'(NUM_POINTS - 1));
    assign st.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid    = m_tvalid_reg;
    assign m_tdata     = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg       <= op_t'(s_tuser);
            idx_reg      <= s_tdata[9:0];
            in_range_reg <= (32'(s_tdata[9:0]) < 32'(NUM_POINTS));
            px_reg       <= s_tdata[31:10];
            py_reg       <= s_tdata[53:32];
            dt2_reg      <= s_tdata[85:54];
            mx_reg       <= s_tdata[107:86];
            my_reg       <= s_tdata[129:108];
            mpx_reg      <= s_tdata[151:130];
            mpy_reg      <= s_tdata[173:152];
            left_reg     <= s_tdata[174];
            right_reg    <= s_tdata[175];
            blast_reg    <= s_tdata[176];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            cur_rd_reg   <= cur_mem[addr];
            prev_rd_reg  <= prev_mem[addr];
            start_rd_reg <= start_mem[addr];
            pin_rd_reg   <= pin_mem[addr];
        end
    end

    // pick test and impulse
    logic signed [POS_W-1:0] cx, cy, prx, pry;
    logic signed [22:0]      dx, dy, ddx, ddy;
    logic [22:0]             adx, ady;
    logic                    sel, impulse;
    logic signed [32:0]      bprod, p;
    logic signed [23:0]      es, clx, cly;
    logic signed [POS_W-1:0] bx, by, gx, gy, pex_next, pey_next;
    logic signed [41:0]      tpx, tpy;
    logic signed [17:0]      damp_s;

    assign cx     = cur_rd_reg[POS_W-1:0];
    assign cy     = cur_rd_reg[RW-1:POS_W];
    assign prx    = prev_rd_reg[POS_W-1:0];
    assign pry    = prev_rd_reg[RW-1:POS_W];
    assign damp_s = $signed({1'b0, cfg.damping_factor});

    always_comb begin
        dx  = 23'(cx) - 23'(mx_reg);
        dy  = 23'(cy) - 23'(my_reg);
        adx = dx[22] ? 23'(-dx) : 23'(dx);
        ady = dy[22] ? 23'(-dy) : 23'(dy);
        sel = (adx < {7'd0, cfg.cursor_size}) && (ady < {7'd0, cfg.cursor_size});

        bprod = $signed({1'b0, cfg.elasticity}) * cfg.blast_intensity;
        p     = bprod >>> FRAC_BITS;
        bx    = sat_pos(40'(cx) - 40'(p));
        by    = cfg.blast_intensity[15] ? sat_pos(40'(cy) - 40'(p))
                                        : sat_pos(40'(cy) + 40'(p));

        es  = $signed({8'd0, cfg.elasticity});
        ddx = 23'(mx_reg) - 23'(mpx_reg);
        ddy = 23'(my_reg) - 23'(mpy_reg);
        if (ddx > es) clx = es;
        else if (ddx < -es) clx = -es;
        else clx = 24'(ddx);
        if (ddy > es) cly = es;
        else if (ddy < -es) cly = -es;
        else cly = 24'(ddy);
        gx = sat_pos(40'(cx) - 40'(clx));
        gy = sat_pos(40'(cy) - 40'(cly));

        impulse = (op_reg == OP_UPDATE) && sel && left_reg;
        if (impulse) begin
            pex_next = blast_reg ? bx : gx;
            pey_next = blast_reg ? by : gy;
        end else begin
            pex_next = prx;
            pey_next = pry;
        end

        tpx = cfg.accel_x * damp_s;
        tpy = cfg.accel_y * damp_s;
    end

    always_ff @(posedge aclk) begin
        if (cmd.imp) begin
            pex_reg <= pex_next;
            pey_reg <= pey_next;
            sel_reg <= sel;
            tx_reg  <= 26'(tpx >>> DAMP_SHIFT);
            ty_reg  <= 26'(tpy >>> DAMP_SHIFT);
        end
    end

    // velocity and acceleration products
    logic signed [22:0] vdx, vdy;
    logic signed [40:0] vpx, vpy;
    logic signed [58:0] apx, apy;
    logic signed [32:0] dt_s;

    always_comb begin
        dt_s = $signed({1'b0, dt2_reg});
        vdx  = 23'(cx) - 23'(pex_reg);
        vdy  = 23'(cy) - 23'(pey_reg);
        vpx  = vdx * damp_s;
        vpy  = vdy * damp_s;
        apx  = tx_reg * dt_s;
        apy  = ty_reg * dt_s;
    end

    always_ff @(posedge aclk) begin
        if (cmd.vel) begin
            vx_reg <= 25'(vpx >>> DAMP_SHIFT);
            vy_reg <= 25'(vpy >>> DAMP_SHIFT);
            ax_reg <= 27'(apx >>> DT_SHIFT);
            ay_reg <= 27'(apy >>> DT_SHIFT);
        end
    end

    // integrate, restrict to the window and pick what to store
    logic signed [31:0]      nx, ny, ex, ey;
    logic signed [POS_W-1:0] fcx, fcy, fpx, fpy, ox, oy;
    logic                    o_pick, o_snap;

    always_comb begin
        nx = 32'(cx) + 32'(vx_reg) + 32'(ax_reg);
        ny = 32'(cy) + 32'(vy_reg) + 32'(ay_reg);
        ex = $signed({12'd0, cfg.window_width});
        ey = $signed({12'd0, cfg.window_height});

        if (pin_rd_reg) begin
            fcx = start_rd_reg[POS_W-1:0];
            fcy = start_rd_reg[RW-1:POS_W];
            fpx = pex_reg;
            fpy = pey_reg;
        end else begin
            if (nx > ex) begin
                fcx = ex[POS_W-1:0];
                fpx = sat_pos(40'(ex) + 40'(OFF));
            end else if (nx < 0) begin
                fcx = '0;
                fpx = sat_pos(-40'(OFF));
            end else begin
                fcx = nx[POS_W-1:0];
                fpx = cx;
            end
            if (ny > ey) begin
                fcy = ey[POS_W-1:0];
                fpy = sat_pos(40'(ey) + 40'(OFF));
            end else if (ny < 0) begin
                fcy = '0;
                fpy = sat_pos(-40'(OFF));
            end else begin
                fcy = ny[POS_W-1:0];
                fpy = cy;
            end
        end

        o_pick = 1'b0;
        o_snap = 1'b0;
        if (!in_range_reg) begin
            ox = '0;
            oy = '0;
        end else begin
            unique case (op_reg)
                OP_INIT, OP_SET: begin
                    ox = px_reg;
                    oy = py_reg;
                end
                OP_PIN: begin
                    ox = cx;
                    oy = cy;
                end
                OP_UPDATE: begin
                    ox     = fcx;
                    oy     = fcy;
                    o_pick = sel_reg;
                    o_snap = sel_reg && right_reg;
                end
                default: begin
                    ox = cx;
                    oy = cy;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wb && in_range_reg) begin
            unique case (op_reg)
                OP_INIT: begin
                    cur_mem[addr]   <= {py_reg, px_reg};
                    prev_mem[addr]  <= {py_reg, px_reg};
                    start_mem[addr] <= {py_reg, px_reg};
                end
                OP_SET: cur_mem[addr] <= {py_reg, px_reg};
                OP_UPDATE: begin
                    cur_mem[addr]  <= {fcy, fcx};
                    prev_mem[addr] <= {fpy, fpx};
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr) begin
            pin_mem[clr_cnt_reg] <= 1'b0;
        end else if (cmd.wb && in_range_reg && op_reg == OP_INIT) begin
            pin_mem[addr] <= 1'b0;
        end else if (cmd.wb && in_range_reg && op_reg == OP_PIN) begin
            pin_mem[addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.wb) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wb) begin
            m_tdata_reg <= {o_snap, o_pick, oy, ox, idx_reg};
        end
    end

endmodule

### rtl/verlet_point_update.sv
`timescale 1ns / 1ps
// Mass-point table with damped Verlet update.
// Input words arrive on s_* (opcode in s_tuser), one result word per input
// leaves on m_*. Configuration sits behind the APB port; write it only
// while the block is idle.
// Each word passes these steps from acceptance to the result register:
// accept, table read, pick/impulse with acceleration product, velocity and
// dt-squared products, then write-back. The read-modify-write of one point
// record means a new word is taken only once the last is through: the next
// word is taken in the cycle after write-back.
// After reset the pinned flags are cleared, one entry a cycle, over all
// NUM_POINTS entries; s_tready stays low during that pass, APB writes are
// taken as ever.
// If the receiver stalls, the result holds in the output register; the
// next word may be accepted and worked on, and its write-back waits until
// the output register is taken.
module verlet_point_update #(
    parameter int NUM_POINTS = vpu_pkg::NUM_POINTS_DEF,
    parameter int FRAC_BITS  = vpu_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // point_index, pos_x, pos_y, dt_squared, mouse_x, mouse_y, mouse_prev_x,
    // mouse_prev_y, left_pressed, right_pressed, blast_active, zero pad
    input  logic [vpu_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode
    input  logic [vpu_pkg::OP_W-1:0]       s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_index, out_x, out_y, picked, snap_links
    output logic [vpu_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vpu_pkg::CFG_AW-1:0]     paddr,
    input  logic [vpu_pkg::CFG_DW-1:0]     pwdata,
    output logic [vpu_pkg::CFG_DW-1:0]     prdata,
    output logic                           pready
);
    import vpu_pkg::*;

    cfg_t    cfg;
    cmd_t    cmd;
    status_t st;

    vpu_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vpu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    vpu_dp #(
        .NUM_POINTS (NUM_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .st       (st),
        .cfg      (cfg),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_wb_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wb |-> st.out_free)
        else $error("write-back while output register is occupied");

    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while one is in flight");

    a_wb_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wb |=> m_tvalid)
        else $error("write-back did not raise m_tvalid");

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept, cmd.rd, cmd.imp, cmd.vel, cmd.wb, cmd.clr}))
        else $error("overlapping datapath commands");

endmodule
